// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked only while the block is out of reset.
`define KTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property that is checked at every clock edge, reset included.
`define KTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/kts_pkg.sv
// Types and constants shared by the keyframe track sampler modules.
`timescale 1ns / 1ps

package kts_pkg;

    localparam int TIME_W  = 32;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;
    localparam int N_COMP  = 4;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int QDEPTH  = 2;

    // Iteration counts of the shared remainder / divide unit, and the last mix step.
    localparam logic [5:0] MOD_STEPS = 6'd33;
    localparam logic [5:0] DIV_STEPS = 6'd16;
    localparam logic [2:0] MIX_LAST  = 3'd4;

    // Segments shorter than this (raw Q16.16 units) hold the earlier key.
    localparam logic signed [TIME_W:0] NEAR_ZERO_SEG = 33'sd7;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_PLAYING   = 3'd0,
        REG_LOOP      = 3'd1,
        REG_INTERP    = 3'd2,
        REG_KEY_COUNT = 3'd3,
        REG_DURATION  = 3'd4
    } t_reg;

    typedef logic [N_COMP-1:0][VAL_W-1:0] t_vec;

    typedef struct packed {
        logic               playing;
        logic               loop_enable;
        logic               interp_mode;
        logic [COUNT_W-1:0] key_count;
        logic [TIME_W-1:0]  track_duration;
        logic               clear_time;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  key_index;
        logic [TIME_W-1:0] key_time;
        t_vec              key_vals;
        logic [TIME_W-1:0] time_step;
    } t_cmd;

endpackage

// File: hdl/kts_front.sv
// Input side: accepts items, drops advances while stopped, and queues the rest.
`timescale 1ns / 1ps

module kts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  kts_pkg::t_cmd i_item,
    input  logic          i_playing,
    output logic          o_q_valid,
    input  logic          i_q_pop,
    output kts_pkg::t_cmd o_q_cmd
);

    localparam int QPW = $clog2(kts_pkg::QDEPTH);
    localparam int QCW = $clog2(kts_pkg::QDEPTH + 1);

    kts_pkg::t_cmd  r_slot [kts_pkg::QDEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QCW-1:0] r_count;

    logic w_keep;
    logic w_push;
    logic w_pop;

    // An advance while stopped is taken and discarded: it changes nothing.
    assign w_keep    = (i_item.op == kts_pkg::OP_LOAD) || i_playing;
    assign o_ready   = (r_count != QCW'(kts_pkg::QDEPTH));
    assign w_push    = i_valid && o_ready && w_keep;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QPW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

endmodule

// File: hdl/kts_engine.sv
// Back end: key memories, time update, key search, factor divide and mix.
`timescale 1ns / 1ps

module kts_engine #(
    parameter int MAX_KEYS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kts_pkg::t_cfg                      i_cfg,
    input  logic                               i_q_valid,
    output logic                               o_q_pop,
    input  kts_pkg::t_cmd                      i_q_cmd,
    output logic                               o_valid,
    input  logic                               i_ready,
    output kts_pkg::t_vec                      o_vals,
    output logic [kts_pkg::TIME_W-1:0]         o_sample_time,
    output logic [kts_pkg::IDX_W-1:0]          o_segment_start
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int NW = (CW > kts_pkg::COUNT_W) ? CW : kts_pkg::COUNT_W;
    localparam int TW = kts_pkg::TIME_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_TIME = 10'b0000000010,
        S_MOD  = 10'b0000000100,
        S_SCAN = 10'b0000001000,
        S_SEG  = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_VA   = 10'b0001000000,
        S_VB   = 10'b0010000000,
        S_MIX  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [TW-1:0]          mem_t [MAX_KEYS];
    kts_pkg::t_vec          mem_v [MAX_KEYS];
    logic [TW-1:0]          r_tdata;
    kts_pkg::t_vec          r_vdata;

    logic [TW-1:0]          r_play_time;
    logic [TW:0]            r_sum;
    logic [TW:0]            r_rem;
    logic [TW:0]            r_dvd;
    logic [TW-1:0]          r_seg;
    logic [14:0]            r_q;
    logic [5:0]             r_cnt;
    logic [CW-1:0]          r_ai;
    logic [CW-1:0]          r_pidx;
    logic                   r_pend;
    logic [TW-1:0]          r_tprev;
    logic [TW-1:0]          r_t1;
    logic [AW-1:0]          r_prev;
    logic [AW-1:0]          r_next;
    logic                   r_hold;
    logic [16:0]            r_f;
    kts_pkg::t_vec          r_a;
    kts_pkg::t_vec          r_res;
    logic signed [50:0]     r_prod;
    logic [2:0]             r_k;

    logic                   r_ovalid;
    kts_pkg::t_vec          r_out_vals;
    logic [TW-1:0]          r_out_time;
    logic [AW-1:0]          r_out_seg;

    logic [NW-1:0]          w_kc;
    logic [NW-1:0]          w_nclamp;
    logic [CW-1:0]          w_n;
    logic [CW-1:0]          w_nm1;
    logic [CW-1:0]          w_pm1;
    logic                   w_wr;
    logic [AW-1:0]          w_waddr;
    logic                   w_t_rd;
    logic                   w_v_rd;
    logic [AW-1:0]          w_v_addr;
    logic [TW-1:0]          w_dsr;
    logic [TW:0]            w_shl;
    logic                   w_ge;
    logic [TW:0]            w_nrem;
    logic signed [TW:0]     w_seg;
    logic signed [TW:0]     w_num;
    logic [1:0]             w_kc2;
    logic [1:0]             w_km1;
    logic signed [TW:0]     w_diff;
    logic signed [50:0]     w_prod;
    logic signed [50:0]     w_prod_sh;

    // Keys in use, capped at the memory depth.
    assign w_kc     = NW'(i_cfg.key_count);
    assign w_nclamp = (w_kc > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : w_kc;
    assign w_n      = w_nclamp[CW-1:0];
    assign w_nm1    = w_n - CW'(1);
    assign w_pm1    = r_pidx - CW'(1);

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign w_wr     = o_q_pop && (i_q_cmd.op == kts_pkg::OP_LOAD)
                      && (32'(i_q_cmd.key_index) < MAX_KEYS);
    assign w_waddr  = AW'(i_q_cmd.key_index);

    assign w_t_rd   = (r_state == S_SCAN) && (r_ai < w_n);
    assign w_v_rd   = (r_state == S_VA) || ((r_state == S_VB) && !r_hold);
    assign w_v_addr = (r_state == S_VA) ? r_prev : r_next;

    // Shared restoring step: remainder of the wrap, or one factor bit.
    assign w_dsr  = (r_state == S_MOD) ? i_cfg.track_duration : r_seg;
    assign w_shl  = {r_rem[TW-1:0], (r_state == S_MOD) ? r_dvd[TW] : 1'b0};
    assign w_ge   = (w_shl >= {1'b0, w_dsr});
    assign w_nrem = w_ge ? (w_shl - {1'b0, w_dsr}) : w_shl;

    assign w_seg  = $signed({1'b0, r_t1}) - $signed({1'b0, r_tprev});
    assign w_num  = $signed({1'b0, r_play_time}) - $signed({1'b0, r_tprev});

    assign w_kc2     = r_k[1:0];
    assign w_km1     = 2'(r_k - 3'd1);
    assign w_diff    = $signed({r_vdata[w_kc2][TW-1], r_vdata[w_kc2]})
                       - $signed({r_a[w_kc2][TW-1], r_a[w_kc2]});
    assign w_prod    = w_diff * $signed({1'b0, r_f});
    assign w_prod_sh = r_prod >>> 16;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_t[w_waddr] <= i_q_cmd.key_time;
            mem_v[w_waddr] <= i_q_cmd.key_vals;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_t_rd) begin
            r_tdata <= mem_t[r_ai[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_v_rd) begin
            r_vdata <= mem_v[w_v_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_play_time <= '0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && (i_q_cmd.op == kts_pkg::OP_ADVANCE)) begin
                        r_sum   <= {1'b0, r_play_time} + {1'b0, i_q_cmd.time_step};
                        r_state <= S_TIME;
                    end
                end
                S_TIME: begin
                    r_ai   <= '0;
                    r_pend <= 1'b0;
                    if (r_sum > {1'b0, i_cfg.track_duration}) begin
                        if (!i_cfg.loop_enable) begin
                            r_play_time <= i_cfg.track_duration;
                            r_state     <= S_SCAN;
                        end else if (i_cfg.track_duration == '0) begin
                            r_play_time <= '0;
                            r_state     <= S_SCAN;
                        end else begin
                            r_rem   <= '0;
                            r_dvd   <= r_sum;
                            r_cnt   <= kts_pkg::MOD_STEPS;
                            r_state <= S_MOD;
                        end
                    end else begin
                        r_play_time <= r_sum[TW-1:0];
                        r_state     <= S_SCAN;
                    end
                end
                S_MOD: begin
                    r_rem <= w_nrem;
                    r_dvd <= {r_dvd[TW-1:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_play_time <= w_nrem[TW-1:0];
                        r_ai        <= '0;
                        r_pend      <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_n == '0) begin
                        r_res   <= '0;
                        r_prev  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        if (w_t_rd) begin
                            r_ai <= r_ai + CW'(1);
                        end
                        r_pend <= w_t_rd;
                        r_pidx <= r_ai;
                        if (r_pend) begin
                            if ((r_pidx != '0) && (r_play_time < r_tdata)) begin
                                r_prev  <= w_pm1[AW-1:0];
                                r_next  <= r_pidx[AW-1:0];
                                r_t1    <= r_tdata;
                                r_state <= S_SEG;
                            end else if (r_pidx == w_nm1) begin
                                // No later key: hold the last one.
                                r_prev  <= r_pidx[AW-1:0];
                                r_hold  <= 1'b1;
                                r_state <= S_VA;
                            end else begin
                                r_tprev <= r_tdata;
                            end
                        end
                    end
                end
                S_SEG: begin
                    if (i_cfg.interp_mode || (w_seg < kts_pkg::NEAR_ZERO_SEG)
                        || (w_num <= 0)) begin
                        r_hold  <= 1'b1;
                        r_state <= S_VA;
                    end else if (w_num >= w_seg) begin
                        r_f     <= kts_pkg::ONE_Q16;
                        r_hold  <= 1'b0;
                        r_state <= S_VA;
                    end else begin
                        r_rem   <= {1'b0, w_num[TW-1:0]};
                        r_seg   <= w_seg[TW-1:0];
                        r_q     <= '0;
                        r_cnt   <= kts_pkg::DIV_STEPS;
                        r_hold  <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_nrem;
                    r_q   <= {r_q[13:0], w_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_f     <= {1'b0, r_q, w_ge};
                        r_state <= S_VA;
                    end
                end
                S_VA: begin
                    r_state <= S_VB;
                end
                S_VB: begin
                    r_a <= r_vdata;
                    if (r_hold) begin
                        r_res   <= r_vdata;
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (r_k != kts_pkg::MIX_LAST) begin
                        r_prod <= w_prod;
                    end
                    if (r_k != '0) begin
                        r_res[w_km1] <= r_a[w_km1] + w_prod_sh[TW-1:0];
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == kts_pkg::MIX_LAST) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out_vals <= r_res;
                        r_out_time <= r_play_time;
                        r_out_seg  <= r_prev;
                        r_ovalid   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg.clear_time) begin
                r_play_time <= '0;
            end
        end
    end

    assign o_valid         = r_ovalid;
    assign o_vals          = r_out_vals;
    assign o_sample_time   = r_out_time;
    assign o_segment_start = kts_pkg::IDX_W'(r_out_seg);

endmodule

// File: hdl/keyframe_track_sampler.sv
// Top level of the keyframe track sampler: register port, front end and engine.
// A load item is queued, then written to the key memories once the idle engine
// takes it; an advance runs the time update (with the remainder steps of the shared
// divide unit when the play time wraps), the key scan, the factor divide and the mix.
// An advance is done before the next is taken; loads drain one per cycle while idle.
// Reset is synchronous and active low: registers, play time, queue and output
// valid clear at once; key memories hold nothing until written and need no pass.
`timescale 1ns / 1ps

module keyframe_track_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Item input channel.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [kts_pkg::IDX_W-1:0]     i_key_index,
    input  logic [kts_pkg::TIME_W-1:0]    i_key_time,
    input  logic signed [31:0]            i_key_x,
    input  logic signed [31:0]            i_key_y,
    input  logic signed [31:0]            i_key_z,
    input  logic signed [31:0]            i_key_w,
    input  logic [kts_pkg::TIME_W-1:0]    i_time_step,

    // Result channel.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_out_x,
    output logic signed [31:0]            o_out_y,
    output logic signed [31:0]            o_out_z,
    output logic signed [31:0]            o_out_w,
    output logic [kts_pkg::TIME_W-1:0]    o_sample_time,
    output logic [kts_pkg::IDX_W-1:0]     o_segment_start,

    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kts_pkg::ADDR_W-1:0]    paddr,
    input  logic [kts_pkg::DATA_W-1:0]    pwdata,
    output logic [kts_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic                             r_playing;
    logic                             r_loop_enable;
    logic                             r_interp_mode;
    logic [kts_pkg::COUNT_W-1:0]      r_key_count;
    logic [kts_pkg::TIME_W-1:0]       r_track_duration;

    logic                             w_wr;
    logic [2:0]                       w_reg_idx;
    kts_pkg::t_cfg                    w_cfg;
    kts_pkg::t_cmd                    w_item;
    logic                             w_q_valid;
    logic                             w_q_pop;
    kts_pkg::t_cmd                    w_q_cmd;
    kts_pkg::t_vec                    w_vals;

    // The port never inserts wait states. Registers sit on word addresses, so
    // the two low address bits do not take part in decoding.
    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[kts_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing        <= 1'b0;
            r_loop_enable    <= 1'b0;
            r_interp_mode    <= 1'b0;
            r_key_count      <= '0;
            r_track_duration <= '0;
        end else if (w_wr) begin
            unique case (kts_pkg::t_reg'(w_reg_idx))
                kts_pkg::REG_PLAYING:   r_playing        <= pwdata[0];
                kts_pkg::REG_LOOP:      r_loop_enable    <= pwdata[0];
                kts_pkg::REG_INTERP:    r_interp_mode    <= pwdata[0];
                kts_pkg::REG_KEY_COUNT: r_key_count      <= pwdata[kts_pkg::COUNT_W-1:0];
                kts_pkg::REG_DURATION:  r_track_duration <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (kts_pkg::t_reg'(w_reg_idx))
            kts_pkg::REG_PLAYING:   prdata[0] = r_playing;
            kts_pkg::REG_LOOP:      prdata[0] = r_loop_enable;
            kts_pkg::REG_INTERP:    prdata[0] = r_interp_mode;
            kts_pkg::REG_KEY_COUNT: prdata[kts_pkg::COUNT_W-1:0] = r_key_count;
            kts_pkg::REG_DURATION:  prdata = r_track_duration;
            default:                prdata = '0;
        endcase
    end

    // Any write of the playing register restarts the track from time zero.
    // Configuration is to be changed by the user only while the block is idle (the
    // block does not enforce it), so that the engine sees the clear between items.
    always_comb begin
        w_cfg.playing        = r_playing;
        w_cfg.loop_enable    = r_loop_enable;
        w_cfg.interp_mode    = r_interp_mode;
        w_cfg.key_count      = r_key_count;
        w_cfg.track_duration = r_track_duration;
        w_cfg.clear_time     = w_wr
                               && (w_reg_idx == 3'(kts_pkg::REG_PLAYING));
    end

    always_comb begin
        w_item.op          = kts_pkg::t_op'(i_op);
        w_item.key_index   = i_key_index;
        w_item.key_time    = i_key_time;
        w_item.key_vals[0] = i_key_x;
        w_item.key_vals[1] = i_key_y;
        w_item.key_vals[2] = i_key_z;
        w_item.key_vals[3] = i_key_w;
        w_item.time_step   = i_time_step;
    end

    // The front end takes an item whenever its two-entry queue has room, so
    // the input keeps flowing while the engine works or a result waits.
    kts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (w_item),
        .i_playing (r_playing),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_cmd   (w_q_cmd)
    );

    // The engine writes keys, steps the play time (wrap by an iterative
    // remainder or clamp), scans the key times one per cycle, derives the
    // Q1.16 factor bit by bit and mixes the four components on one multiplier.
    // Its output register holds the finished result until it is taken.
    kts_engine #(
        .MAX_KEYS (MAX_KEYS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_q_valid       (w_q_valid),
        .o_q_pop         (w_q_pop),
        .i_q_cmd         (w_q_cmd),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_vals          (w_vals),
        .o_sample_time   (o_sample_time),
        .o_segment_start (o_segment_start)
    );

    assign o_out_x = w_vals[0];
    assign o_out_y = w_vals[1];
    assign o_out_z = w_vals[2];
    assign o_out_w = w_vals[3];

endmodule

// File: hdl/kts_checker.sv
// Port-level assertions for the keyframe track sampler, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kts_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [31:0]                 o_out_x,
    input logic [31:0]                 o_out_y,
    input logic [31:0]                 o_out_z,
    input logic [31:0]                 o_out_w,
    input logic [kts_pkg::TIME_W-1:0]  o_sample_time,
    input logic [kts_pkg::IDX_W-1:0]   o_segment_start,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [kts_pkg::ADDR_W-1:0]  paddr,
    input logic [kts_pkg::DATA_W-1:0]  pwdata,
    input logic [kts_pkg::DATA_W-1:0]  prdata,
    input logic                        pready
);

    // Reset drops any pending result.
    `KTS_ASSERT_ALWAYS(a_rst_clears_valid, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    // A stalled result item stays and keeps its value.
    `KTS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_out_w) && $stable(o_sample_time) && $stable(o_segment_start), "stalled result changed")

    // The register port never stalls.
    `KTS_ASSERT_ALWAYS(a_pready_high, i_clk, pready, "register port stalled")

    // A key count written and read back in the next cycle returns the value.
    `KTS_ASSERT(a_key_count_rb, i_clk, i_rst_n, (psel && penable && pwrite && paddr[4:2] == kts_pkg::REG_KEY_COUNT) ##1 (psel && !pwrite && paddr[4:2] == kts_pkg::REG_KEY_COUNT) |-> prdata[6:0] == $past(pwdata[6:0]) && prdata[31:7] == '0, "key count read back wrong")

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_out_x         (o_out_x),
    .o_out_y         (o_out_y),
    .o_out_z         (o_out_z),
    .o_out_w         (o_out_w),
    .o_sample_time   (o_sample_time),
    .o_segment_start (o_segment_start),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
);

// File: tb/sv/tb.sv
// Self-checking testbench for the keyframe track sampler, with its own track model.
`timescale 1ns / 1ps

module tb;

    import kts_pkg::*;

    localparam int          MAX_SLOTS     = 64;
    localparam longint      Q16_ONE       = 65536;
    localparam longint      SHORT_SEGMENT = 7;
    // Covers the worst advance, a full key scan with a wrap, with margin.
    localparam int          SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 1000;
    localparam int unsigned TOTAL_ITEMS   = 1250;
    localparam int          PRINT_CAP     = 50;

    // One sampled value as the block returns it.
    typedef struct packed {
        t_vec              vals;
        logic [TIME_W-1:0] when;
        logic [IDX_W-1:0]  seg;
    } sample_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_op = 1'b0;
    logic [IDX_W-1:0]     i_key_index = '0;
    logic [TIME_W-1:0]    i_key_time = '0;
    logic signed [31:0]   i_key_x = '0;
    logic signed [31:0]   i_key_y = '0;
    logic signed [31:0]   i_key_z = '0;
    logic signed [31:0]   i_key_w = '0;
    logic [TIME_W-1:0]    i_time_step = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [31:0]   o_out_x;
    logic signed [31:0]   o_out_y;
    logic signed [31:0]   o_out_z;
    logic signed [31:0]   o_out_w;
    logic [TIME_W-1:0]    o_sample_time;
    logic [IDX_W-1:0]     o_segment_start;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // Track model: registers, play time and key store.
    logic                 m_playing = 1'b0;
    logic                 m_loop = 1'b0;
    logic                 m_step_mode = 1'b0;
    logic [COUNT_W-1:0]   m_key_count = '0;
    logic [TIME_W-1:0]    m_duration = '0;
    logic [TIME_W-1:0]    m_play_time = '0;
    logic [TIME_W-1:0]    m_key_time [MAX_SLOTS];
    t_vec                 m_key_val [MAX_SLOTS];

    sample_t              samples_due [$];
    int unsigned          mismatch_count = 0;
    int unsigned          items_sent = 0;
    int unsigned          cycle_count = 0;
    int                   hold_off_cycles = 0;
    bit                   calm = 1'b0;

    keyframe_track_sampler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_key_index     (i_key_index),
        .i_key_time      (i_key_time),
        .i_key_x         (i_key_x),
        .i_key_y         (i_key_y),
        .i_key_z         (i_key_z),
        .i_key_w         (i_key_w),
        .i_time_step     (i_time_step),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_out_w         (o_out_w),
        .o_sample_time   (o_sample_time),
        .o_segment_start (o_segment_start),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mixes a toward b by a Q1.16 factor; the arithmetic shift floors the product.
    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint f);
        longint sa;
        longint diff;
        longint mixed;
        sa    = longint'(signed'(a));
        diff  = longint'(signed'(b)) - sa;
        mixed = sa + ((diff * f) >>> 16);
        return mixed[31:0];
    endfunction

    // Applies one accepted item to the track model and queues the sample it yields.
    function automatic void predict_sample(t_cmd c);
        logic [TIME_W:0] sum;
        int              n;
        int              prev;
        int              nxt;
        bit              found;
        longint          t0;
        longint          seg;
        longint          num;
        longint          f;
        sample_t         s;
        if (c.op == OP_LOAD) begin
            m_key_time[c.key_index] = c.key_time;
            m_key_val[c.key_index]  = c.key_vals;
            return;
        end
        if (!m_playing) begin
            return;
        end
        sum = {1'b0, m_play_time} + {1'b0, c.time_step};
        if (sum > {1'b0, m_duration}) begin
            if (m_loop) begin
                sum = (m_duration == 0) ? '0 : sum % m_duration;
            end else begin
                sum = {1'b0, m_duration};
            end
        end
        m_play_time = sum[TIME_W-1:0];

        n      = (m_key_count > MAX_SLOTS) ? MAX_SLOTS : int'(m_key_count);
        prev   = 0;
        s.vals = '0;
        if (n == 1) begin
            s.vals = m_key_val[0];
        end else if (n > 1) begin
            found = 1'b0;
            nxt   = 0;
            for (int k = 0; k + 1 < n && !found; k++) begin
                if (m_play_time < m_key_time[k + 1]) begin
                    nxt   = k + 1;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // Past the last key: hold it.
                prev   = n - 1;
                s.vals = m_key_val[prev];
            end else begin
                prev = nxt - 1;
                t0   = longint'(m_key_time[prev]);
                seg  = longint'(m_key_time[nxt]) - t0;
                if (m_step_mode || seg < SHORT_SEGMENT) begin
                    s.vals = m_key_val[prev];
                end else begin
                    num = longint'(m_play_time) - t0;
                    f   = 0;
                    if (num > 0) begin
                        f = (num * Q16_ONE) / seg;
                        if (f > Q16_ONE) begin
                            f = Q16_ONE;
                        end
                    end
                    for (int k = 0; k < N_COMP; k++) begin
                        s.vals[k] = blend(m_key_val[prev][k], m_key_val[nxt][k], f);
                    end
                end
            end
        end
        s.when = m_play_time;
        s.seg  = prev[IDX_W-1:0];
        samples_due.push_back(s);
    endfunction

    function automatic logic [31:0] reg_value(t_reg r);
        case (r)
            REG_PLAYING:   return {31'b0, m_playing};
            REG_LOOP:      return {31'b0, m_loop};
            REG_INTERP:    return {31'b0, m_step_mode};
            REG_KEY_COUNT: return {{(32 - COUNT_W){1'b0}}, m_key_count};
            REG_DURATION:  return m_duration;
            default:       return '0;
        endcase
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP) begin
                $display("%0t ns: mismatch on %s, expected %h, actual %h",
                         $time, what, want, got);
            end
        end
    endfunction

    function automatic t_vec random_vec();
        t_vec v;
        for (int k = 0; k < N_COMP; k++) begin
            v[k] = $urandom;
        end
        return v;
    endfunction

    // Time step for an advance: mostly a fraction of the span, sometimes an extreme.
    function automatic logic [31:0] pick_step(logic [31:0] span);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(0, span / 4 + 1);
        endcase
    endfunction

    // Register port: a setup phase, an access phase, then psel drops back to idle.
    task automatic write_reg(t_reg r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            REG_PLAYING: begin
                m_playing   = v[0];
                m_play_time = '0;
            end
            REG_LOOP:      m_loop = v[0];
            REG_INTERP:    m_step_mode = v[0];
            REG_KEY_COUNT: m_key_count = v[COUNT_W-1:0];
            REG_DURATION:  m_duration = v;
            default: begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(t_reg r);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        check_field({"register ", r.name()}, reg_value(r), got);
    endtask

    // Offers one item, with an occasional gap before it, and waits for acceptance.
    // Valid is left high so that a following item can go out on the next cycle.
    task automatic send_item(t_cmd c);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= c.op;
        i_key_index <= c.key_index;
        i_key_time  <= c.key_time;
        i_key_x     <= c.key_vals[0];
        i_key_y     <= c.key_vals[1];
        i_key_z     <= c.key_vals[2];
        i_key_w     <= c.key_vals[3];
        i_time_step <= c.time_step;
        do @(posedge i_clk); while (!o_ready);
        predict_sample(c);
        items_sent++;
    endtask

    task automatic load_key(logic [IDX_W-1:0] slot, logic [31:0] t, t_vec v);
        t_cmd c;
        c.op        = OP_LOAD;
        c.key_index = slot;
        c.key_time  = t;
        c.key_vals  = v;
        c.time_step = $urandom;
        send_item(c);
    endtask

    task automatic advance(logic [31:0] step);
        t_cmd c;
        c.op        = OP_ADVANCE;
        c.key_index = $urandom;
        c.key_time  = $urandom;
        c.key_vals  = random_vec();
        c.time_step = step;
        send_item(c);
    endtask

    // Drops valid and waits until every queued sample has come back.
    task automatic wait_for_samples();
        i_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge i_clk);
    endtask

    // Loads leave no sample behind, so also give the block time to finish them.
    task automatic settle();
        wait_for_samples();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes keys into slots 0 to n-1, non-decreasing in time unless told otherwise.
    task automatic build_track(int n, bit ordered, output logic [31:0] last_time);
        logic [31:0] t;
        int          pick;
        t         = $urandom_range(0, 'h8000);
        last_time = '0;
        for (int k = 0; k < n; k++) begin
            if (!ordered) begin
                t = $urandom;
            end
            load_key(k[IDX_W-1:0], t, random_vec());
            last_time = t;
            pick = $urandom_range(0, 9);
            if (pick == 1) begin
                t += $urandom_range(1, 8);
            end else if (pick > 1) begin
                t += $urandom_range(9, 'h3_0000);
            end
        end
    endtask

    // Builds a fresh track and sets up playback over it. Only slots that were just
    // written are ever put into use, so the block never reads an empty slot.
    task automatic prepare_track(bit must_play, output logic [31:0] span);
        int          n;
        logic [31:0] last_time;
        logic [31:0] dur;
        case ($urandom_range(0, 19))
            0:       n = 0;
            1:       n = 1;
            2:       n = MAX_SLOTS;
            default: n = $urandom_range(2, 8);
        endcase
        build_track(n, $urandom_range(0, 7) != 0, last_time);
        case ($urandom_range(0, 7))
            0:       dur = '0;
            1:       dur = '1;
            2:       dur = $urandom;
            3:       dur = last_time >> 1;
            default: dur = last_time + $urandom_range(0, 'h2_0000);
        endcase
        settle();
        write_reg(REG_KEY_COUNT, n);
        write_reg(REG_LOOP, $urandom_range(0, 1));
        write_reg(REG_INTERP, $urandom_range(0, 3) == 0);
        write_reg(REG_DURATION, dur);
        write_reg(REG_PLAYING, must_play || $urandom_range(0, 11) != 0);
        span = (dur == 0) ? 32'h1_0000 : dur;
    endtask

    task automatic run_scenario();
        logic [31:0] span;
        prepare_track(1'b0, span);
        repeat ($urandom_range(8, 30)) begin
            // Now and then a stray load lands in the middle of playback.
            if ($urandom_range(0, 9) == 0) begin
                load_key($urandom, $urandom, random_vec());
            end else begin
                advance(pick_step(span));
            end
        end
    endtask

    task automatic test_register_access();
        t_reg r;
        write_reg(REG_PLAYING, 1);
        write_reg(REG_LOOP, 1);
        write_reg(REG_INTERP, 1);
        write_reg(REG_KEY_COUNT, MAX_SLOTS);
        write_reg(REG_DURATION, '1);
        r = r.first();
        repeat (r.num()) begin
            check_reg(r);
            r = r.next();
        end
        write_reg(REG_PLAYING, 0);
        write_reg(REG_LOOP, 0);
        write_reg(REG_INTERP, 0);
        write_reg(REG_KEY_COUNT, 0);
        write_reg(REG_DURATION, 0);
        r = r.first();
        repeat (r.num()) begin
            check_reg(r);
            r = r.next();
        end
    endtask

    // An advance while stopped changes nothing and returns nothing.
    task automatic test_idle_advance();
        advance(32'h0001_0000);
    endtask

    task automatic test_empty_track();
        settle();
        write_reg(REG_DURATION, 32'h0005_0000);
        write_reg(REG_PLAYING, 1);
        advance(32'h0001_0000);
        advance('1);
    endtask

    // Keys at the time extremes with the component extremes, and a segment of
    // only three raw units between keys 1 and 2.
    task automatic test_boundary_keys();
        load_key(0, 32'h0000_0000, {32'hFFFF_FFFF, 32'h0000_0000,
                                    32'h8000_0000, 32'h7FFF_FFFF});
        load_key(1, 32'h0001_0000, {32'h0000_0001, 32'hFFFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000});
        load_key(2, 32'h0001_0003, {32'hFFFF_0000, 32'h0001_0000,
                                    32'hEDCB_A988, 32'h1234_5678});
        load_key(3, 32'hFFFF_FFFF, {32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h0000_0000, 32'h0000_0000});
        load_key(MAX_SLOTS - 1, 32'hFFFF_FFFF, random_vec());
        settle();
        write_reg(REG_KEY_COUNT, 1);
        write_reg(REG_PLAYING, 1);
        advance(32'h0000_4000);
        settle();
        write_reg(REG_KEY_COUNT, 4);
        write_reg(REG_DURATION, '1);
        write_reg(REG_PLAYING, 1);
        advance(32'h0000_0000);
        advance(32'h0000_8000);
        // Lands exactly on key 1, whose segment to key 2 is too short to mix.
        advance(32'h0000_8000);
        advance(32'h0000_0010);
        advance(32'h7FFF_0000);
        // The sum overflows 32 bits and is clamped to the duration: last key held.
        advance('1);
        advance(32'h0000_0001);
    endtask

    task automatic test_step_mode();
        settle();
        write_reg(REG_INTERP, 1);
        write_reg(REG_PLAYING, 1);
        advance(32'h0000_8000);
        advance(32'h0000_C000);
    endtask

    task automatic test_wrap_and_clamp();
        settle();
        write_reg(REG_INTERP, 0);
        write_reg(REG_LOOP, 1);
        write_reg(REG_DURATION, 32'h0001_8000);
        write_reg(REG_PLAYING, 1);
        advance(32'h0002_0000);
        advance('1);
        settle();
        write_reg(REG_LOOP, 0);
        advance(32'h0002_0000);
        settle();
        // Looping over a zero duration always wraps to zero.
        write_reg(REG_LOOP, 1);
        write_reg(REG_DURATION, 0);
        write_reg(REG_PLAYING, 1);
        advance(32'h0000_0005);
    endtask

    task automatic test_random_tracks();
        while (items_sent < RANDOM_ITEMS) begin
            run_scenario();
        end
    endtask

    // The receiver stops for a long stretch while advances keep coming, so the
    // result register and the input queue fill and o_ready drops.
    task automatic test_output_backpressure();
        logic [31:0] span;
        prepare_track(1'b1, span);
        hold_off_cycles = 400;
        repeat (16) begin
            advance($urandom_range(0, span / 8 + 1));
        end
    endtask

    task automatic test_pause_until_drained();
        logic [31:0] span;
        prepare_track(1'b1, span);
        repeat (10) begin
            advance(pick_step(span));
        end
        wait_for_samples();
        repeat (10) begin
            advance(pick_step(span));
        end
    endtask

    // The last stretch runs back to back with no gaps on either side.
    task automatic test_quiet_finish();
        calm = 1'b1;
        while (items_sent < TOTAL_ITEMS) begin
            run_scenario();
        end
    endtask

    // Result side: random stalls, or a long hold-off when a test asks for one.
    initial begin
        int rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                rx_wait         = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (rx_wait == 0 && !calm && $urandom_range(0, 7) == 0) begin
                rx_wait = $urandom_range(1, 12);
            end
            if (rx_wait > 0) begin
                i_ready <= 1'b0;
                rx_wait--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Every result taken is compared with the oldest sample still due.
    always @(posedge i_clk) begin
        sample_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (samples_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= PRINT_CAP) begin
                    $display("%0t ns: unexpected result, expected none, actual time %h",
                             $time, o_sample_time);
                end
            end else begin
                want = samples_due.pop_front();
                check_field("out_x", want.vals[0], o_out_x);
                check_field("out_y", want.vals[1], o_out_y);
                check_field("out_z", want.vals[2], o_out_z);
                check_field("out_w", want.vals[3], o_out_w);
                check_field("sample_time", want.when, o_sample_time);
                check_field("segment_start", want.seg, o_segment_start);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb: errors");
        $finish;
    end

    initial begin
        for (int k = 0; k < MAX_SLOTS; k++) begin
            m_key_time[k] = '0;
            m_key_val[k]  = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_idle_advance();
        test_empty_track();
        test_boundary_keys();
        test_step_mode();
        test_wrap_and_clamp();
        test_random_tracks();
        test_output_backpressure();
        test_pause_until_drained();
        test_quiet_finish();
        settle();

        if (samples_due.size() != 0) begin
            mismatch_count++;
            $display("%0t ns: %0d samples still due at the end", $time, samples_due.size());
        end
        if (mismatch_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
